FILE: sv/audio_frame_loudness_classifier_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the audio frame loudness classifier
// Shorthand for the concurrent checks placed at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef AUDIO_FRAME_LOUDNESS_CLASSIFIER_ASSERT_SVH
`define AUDIO_FRAME_LOUDNESS_CLASSIFIER_ASSERT_SVH

// Condition must never be true while out of reset
`define AFL_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("%m: forbidden condition seen");

// Whenever the antecedent holds, the consequent must hold in the same cycle
`define AFL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: implication violated");

`endif

FILE: sv/afl_pkg.sv
// ----------------------------------------------------------------------------
// Loudness classifier package
// Shared widths, register indexes, label codes and record types.
// ----------------------------------------------------------------------------
package afl_pkg;

  // Frame and counter sizing
  localparam int unsigned FRAME_MAX     = 256;
  localparam int unsigned CNT_W         = $clog2(FRAME_MAX + 1);
  localparam int unsigned QUIET_FRAMES  = 5;
  localparam int unsigned QRUN_W        = $clog2(QUIET_FRAMES + 1);
  localparam int unsigned NORMAL_FRAMES = 2;
  localparam int unsigned NRUN_W        = $clog2(NORMAL_FRAMES + 1);

  // Datapath widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SUM_W    = 25;
  localparam int unsigned SQACC_W  = 40;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PEAK_W   = 16;

  // Record queue between accumulator and classifier
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 88;

  // Impulse test: peak over 12 times rms, squared
  localparam int unsigned IMPULSE_RATIO_SQ = 144;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LOUD_RMS       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOUD_PEAK      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSIENT_PEAK = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPULSE_PEAK   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPULSE_RMS    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_RMS     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_PEAK    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LOUD_HOLD      = 4'd7;

  typedef enum logic [1:0] {
    LABEL_QUIET  = 2'd0,
    LABEL_NORMAL = 2'd1,
    LABEL_LOUD   = 2'd2
  } label_e;

  typedef struct packed {
    logic [14:0] loud_rms;
    logic [15:0] loud_peak;
    logic [15:0] transient_peak;
    logic [15:0] impulse_peak;
    logic [14:0] impulse_rms;
    logic [14:0] normal_rms;
    logic [15:0] normal_peak;
    logic [15:0] hold_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    loud_rms:       15'd350,
    loud_peak:      16'd3200,
    transient_peak: 16'd4800,
    impulse_peak:   16'd2600,
    impulse_rms:    15'd280,
    normal_rms:     15'd120,
    normal_peak:    16'd1200,
    hold_ms:        16'd600
  };

  // Raw statistics of one closed frame
  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [SQACC_W-1:0]  sqacc;
    logic [SAMPLE_W-1:0] min;
    logic [SAMPLE_W-1:0] max;
    logic [CNT_W-1:0]    cnt;
    logic [TIME_W-1:0]   now;
  } frame_rec_t;

  // One classified frame
  typedef struct packed {
    label_e              label;
    logic [PEAK_W-1:0]   peak;
    logic [SAMPLE_W-1:0] mean;
    logic [SQACC_W-1:0]  sq;
    logic [CNT_W-1:0]    cnt;
  } result_t;

endpackage

FILE: sv/afl_front.sv
// ----------------------------------------------------------------------------
// Loudness classifier front end
// Accumulates sum, square sum, min, max and count per frame; pushes a record.
// ----------------------------------------------------------------------------
module afl_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_valid_i,
  output logic                                 s_ready_o,
  input  logic signed [afl_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                 last_i,
  input  logic        [afl_pkg::TIME_W-1:0]    time_i,
  input  logic                                 full_i,
  output logic                                 push_o,
  output afl_pkg::frame_rec_t                  rec_o
);

  logic signed [afl_pkg::SUM_W-1:0]     sum_q, sum_nx;
  logic        [afl_pkg::SQACC_W-1:0]   sqacc_q, sqacc_nx;
  logic signed [afl_pkg::SAMPLE_W-1:0]  min_q, max_q, min_nx, max_nx;
  logic        [afl_pkg::CNT_W-1:0]     cnt_q, cnt_nx;
  logic signed [2*afl_pkg::SAMPLE_W-1:0] sample_sq;
  logic                                 accept;
  logic                                 closes;

  // Take a sample whenever the record queue has room
  assign s_ready_o = !full_i;
  assign accept    = s_valid_i && s_ready_o;

  // Fold the incoming sample into the running statistics
  always_comb begin
    sample_sq = sample_i * sample_i;
    sum_nx    = sum_q + {{(afl_pkg::SUM_W - afl_pkg::SAMPLE_W){sample_i[afl_pkg::SAMPLE_W-1]}},
                         sample_i};
    sqacc_nx  = sqacc_q + {{(afl_pkg::SQACC_W - 2*afl_pkg::SAMPLE_W){1'b0}}, sample_sq};
    min_nx    = (sample_i < min_q) ? sample_i : min_q;
    max_nx    = (sample_i > max_q) ? sample_i : max_q;
    cnt_nx    = cnt_q + 1'b1;
    closes    = last_i || (cnt_nx == afl_pkg::CNT_W'(afl_pkg::FRAME_MAX));
  end

  // Close the frame on the marked sample or when the frame is full
  assign push_o       = accept && closes;
  assign rec_o.sum    = sum_nx;
  assign rec_o.sqacc  = sqacc_nx;
  assign rec_o.min    = min_nx;
  assign rec_o.max    = max_nx;
  assign rec_o.cnt    = cnt_nx;
  assign rec_o.now    = time_i;

  // Advance or clear the accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sqacc_q <= '0;
      min_q   <= {1'b0, {(afl_pkg::SAMPLE_W-1){1'b1}}};
      max_q   <= {1'b1, {(afl_pkg::SAMPLE_W-1){1'b0}}};
      cnt_q   <= '0;
    end else if (accept) begin
      if (closes) begin
        sum_q   <= '0;
        sqacc_q <= '0;
        min_q   <= {1'b0, {(afl_pkg::SAMPLE_W-1){1'b1}}};
        max_q   <= {1'b1, {(afl_pkg::SAMPLE_W-1){1'b0}}};
        cnt_q   <= '0;
      end else begin
        sum_q   <= sum_nx;
        sqacc_q <= sqacc_nx;
        min_q   <= min_nx;
        max_q   <= max_nx;
        cnt_q   <= cnt_nx;
      end
    end
  end

endmodule

FILE: sv/afl_queue.sv
// ----------------------------------------------------------------------------
// Loudness classifier record queue
// Small FIFO of closed-frame records between front end and classifier.
// ----------------------------------------------------------------------------
module afl_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  afl_pkg::frame_rec_t           rec_i,
  output logic                          full_o,
  input  logic                          pop_i,
  output logic                          valid_o,
  output afl_pkg::frame_rec_t           rec_o,
  output logic [afl_pkg::QCNT_W-1:0]    count_o
);

  afl_pkg::frame_rec_t               entry_q [afl_pkg::QUEUE_DEPTH];
  logic [afl_pkg::QPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [afl_pkg::QCNT_W-1:0]        count_q;
  logic                              do_push, do_pop;

  assign full_o  = (count_q == afl_pkg::QCNT_W'(afl_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign rec_o   = entry_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store an incoming record
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= rec_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == afl_pkg::QPTR_W'(afl_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == afl_pkg::QPTR_W'(afl_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: sv/afl_back.sv
// ----------------------------------------------------------------------------
// Loudness classifier back end
// Divides for the mean, forms the centered square sum and the squared
// thresholds on one shared multiplier, classifies and holds the result.
// ----------------------------------------------------------------------------
module afl_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  afl_pkg::cfg_t        cfg_i,
  input  logic                 rec_valid_i,
  input  afl_pkg::frame_rec_t  rec_i,
  output logic                 rec_pop_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output afl_pkg::result_t     m_res_o
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_MUL   = 2'd2;
  localparam logic [1:0] ST_CLASS = 2'd3;

  // Multiplier steps
  localparam logic [3:0] STEP_MEAN_N = 4'd0;
  localparam logic [3:0] STEP_CROSS  = 4'd1;
  localparam logic [3:0] STEP_IR_SQ  = 4'd2;
  localparam logic [3:0] STEP_IR_N   = 4'd3;
  localparam logic [3:0] STEP_LR_SQ  = 4'd4;
  localparam logic [3:0] STEP_LR_N   = 4'd5;
  localparam logic [3:0] STEP_NR_SQ  = 4'd6;
  localparam logic [3:0] STEP_NR_N   = 4'd7;
  localparam logic [3:0] STEP_PK_SQ  = 4'd8;
  localparam logic [3:0] STEP_PK_N   = 4'd9;

  localparam int unsigned DVD_W   = afl_pkg::SUM_W - 1;
  localparam int unsigned DCNT_W  = $clog2(DVD_W);
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 27;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned WIDE_W  = afl_pkg::SQACC_W + 2;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned SQ144_W = afl_pkg::SQACC_W + 8;
  localparam int unsigned SW      = afl_pkg::SAMPLE_W;

  logic [1:0]               state_q;
  logic [DCNT_W-1:0]        dcnt_q;
  logic [3:0]               step_q;

  afl_pkg::frame_rec_t      rec_q;
  logic [DVD_W-1:0]         dvd_q, dvd_nx;
  logic [afl_pkg::CNT_W-1:0] rem_q, rem_nx;
  logic [afl_pkg::CNT_W:0]  rem_sh;
  logic                     div_ge;
  logic                     neg_q;
  logic [SW-1:0]            quo, mean_nx, mean_q;

  logic [afl_pkg::SUM_W-1:0] sum_in, sum_mag;
  logic [afl_pkg::SUM_W-1:0] t_q;
  logic [afl_pkg::SUM_W:0]   cross_u;
  logic [WIDE_W-1:0]         v_q, sq_diff;
  logic [afl_pkg::SQACC_W-1:0] sq_nx, sq_q;
  logic [PROD_W-1:0]         prod_q;
  logic [WIDE_W-1:0]         irn_q, lrn_q, nrn_q, ppn_q;

  logic [SW:0]              mean_x, up, down;
  logic [afl_pkg::PEAK_W-1:0] up_c, down_c, peak_nx, peak_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic [WIDE_W-1:0]        sq_w;
  logic [SQ144_W-1:0]       sq144, ppn_w;
  logic                     is_impulse, is_transient, is_sustained, is_normal, in_hold;
  logic                     is_loud;
  logic [afl_pkg::TIME_W-1:0] hold_diff;
  logic                     out_free, load_out;

  afl_pkg::label_e          label_q, label_nx;
  logic [afl_pkg::QRUN_W-1:0] qrun_q, qrun_inc, qrun_nx;
  logic [afl_pkg::NRUN_W-1:0] nrun_q, nrun_inc, nrun_nx;
  logic [afl_pkg::TIME_W-1:0] deadline_q, deadline_nx;

  logic                     out_valid_q;
  afl_pkg::result_t         out_q;

  // Take a record off the queue when the sequencer is free
  assign rec_pop_o = (state_q == ST_IDLE) && rec_valid_i;

  // Magnitude of the incoming frame sum
  always_comb begin
    sum_in  = rec_i.sum;
    sum_mag = sum_in[afl_pkg::SUM_W-1] ? (~sum_in + 1'b1) : sum_in;
  end

  // One restoring division step per cycle
  always_comb begin
    rem_sh  = {rem_q, dvd_q[DVD_W-1]};
    div_ge  = (rem_sh >= {1'b0, rec_q.cnt});
    rem_nx  = div_ge ? afl_pkg::CNT_W'(rem_sh - {1'b0, rec_q.cnt})
                     : afl_pkg::CNT_W'(rem_sh);
    dvd_nx  = {dvd_q[DVD_W-2:0], div_ge};
    quo     = dvd_nx[SW-1:0];
    mean_nx = neg_q ? (~quo + 1'b1) : quo;
  end

  // Peak deviation from the truncated mean
  always_comb begin
    mean_x  = {mean_q[SW-1], mean_q};
    up      = {rec_q.max[SW-1], rec_q.max} - mean_x;
    down    = mean_x - {rec_q.min[SW-1], rec_q.min};
    up_c    = up[SW] ? '0 : up[SW-1:0];
    down_c  = down[SW] ? '0 : down[SW-1:0];
    peak_nx = (up_c > down_c) ? up_c : down_c;
  end

  // Centered square sum: sqacc - mean * (2 * sum - n * mean)
  always_comb begin
    cross_u = {rec_q.sum, 1'b0} - {t_q[afl_pkg::SUM_W-1], t_q};
    sq_diff = {2'b00, rec_q.sqacc} - v_q;
    sq_nx   = sq_diff[WIDE_W-1] ? '0 : sq_diff[afl_pkg::SQACC_W-1:0];
  end

  // Shared multiplier operand selection
  always_comb begin
    unique case (step_q)
      STEP_MEAN_N: begin
        mul_a = {{(MUL_A_W - afl_pkg::CNT_W){1'b0}}, rec_q.cnt};
        mul_b = {{(MUL_B_W - SW){mean_q[SW-1]}}, mean_q};
      end
      STEP_CROSS: begin
        mul_a = {{(MUL_A_W - afl_pkg::SUM_W - 1){cross_u[afl_pkg::SUM_W]}}, cross_u};
        mul_b = {{(MUL_B_W - SW){mean_q[SW-1]}}, mean_q};
      end
      STEP_IR_SQ: begin
        mul_a = {{(MUL_A_W - 15){1'b0}}, cfg_i.impulse_rms};
        mul_b = {{(MUL_B_W - 15){1'b0}}, cfg_i.impulse_rms};
      end
      STEP_LR_SQ: begin
        mul_a = {{(MUL_A_W - 15){1'b0}}, cfg_i.loud_rms};
        mul_b = {{(MUL_B_W - 15){1'b0}}, cfg_i.loud_rms};
      end
      STEP_NR_SQ: begin
        mul_a = {{(MUL_A_W - 15){1'b0}}, cfg_i.normal_rms};
        mul_b = {{(MUL_B_W - 15){1'b0}}, cfg_i.normal_rms};
      end
      STEP_PK_SQ: begin
        mul_a = {{(MUL_A_W - afl_pkg::PEAK_W){1'b0}}, peak_q};
        mul_b = {{(MUL_B_W - afl_pkg::PEAK_W){1'b0}}, peak_q};
      end
      STEP_IR_N, STEP_LR_N, STEP_NR_N, STEP_PK_N: begin
        mul_a = {{(MUL_A_W - PROD_W){1'b0}}, prod_q};
        mul_b = {{(MUL_B_W - afl_pkg::CNT_W){1'b0}}, rec_q.cnt};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Frame tests as exact squared comparisons
  always_comb begin
    sq_w         = {2'b00, sq_q};
    sq144        = SQ144_W'(sq_q) * SQ144_W'(afl_pkg::IMPULSE_RATIO_SQ);
    ppn_w        = SQ144_W'(ppn_q);
    is_impulse   = (peak_q > cfg_i.impulse_peak) && (sq_w < irn_q) && (ppn_w > sq144);
    is_transient = (peak_q >= cfg_i.transient_peak);
    is_sustained = (sq_w >= lrn_q) && (peak_q >= cfg_i.loud_peak);
    is_normal    = (sq_w >= nrn_q) || (peak_q >= cfg_i.normal_peak);
    is_loud      = is_impulse || is_transient || is_sustained;
    hold_diff    = rec_q.now - deadline_q;
    in_hold      = (label_q == afl_pkg::LABEL_LOUD) && hold_diff[afl_pkg::TIME_W-1];
  end

  // Label update with saturating run counters
  always_comb begin
    label_nx    = label_q;
    qrun_nx     = qrun_q;
    nrun_nx     = nrun_q;
    deadline_nx = deadline_q;
    qrun_inc    = (qrun_q < afl_pkg::QRUN_W'(afl_pkg::QUIET_FRAMES)) ? qrun_q + 1'b1 : qrun_q;
    nrun_inc    = (nrun_q < afl_pkg::NRUN_W'(afl_pkg::NORMAL_FRAMES)) ? nrun_q + 1'b1 : nrun_q;
    priority if (is_loud) begin
      label_nx    = afl_pkg::LABEL_LOUD;
      deadline_nx = rec_q.now + {{(afl_pkg::TIME_W - 16){1'b0}}, cfg_i.hold_ms};
      qrun_nx     = '0;
      nrun_nx     = '0;
    end else if (in_hold) begin
      label_nx    = label_q;
    end else if (is_normal) begin
      nrun_nx = nrun_inc;
      qrun_nx = '0;
      if (nrun_inc >= afl_pkg::NRUN_W'(afl_pkg::NORMAL_FRAMES)) begin
        label_nx = afl_pkg::LABEL_NORMAL;
      end
    end else begin
      qrun_nx = qrun_inc;
      nrun_nx = '0;
      if (qrun_inc >= afl_pkg::QRUN_W'(afl_pkg::QUIET_FRAMES)) begin
        label_nx = afl_pkg::LABEL_QUIET;
      end
    end
  end

  assign out_free = !out_valid_q || m_ready_i;
  assign load_out = (state_q == ST_CLASS) && out_free;

  // Sequencer and classifier state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dcnt_q      <= '0;
      step_q      <= STEP_MEAN_N;
      label_q     <= afl_pkg::LABEL_QUIET;
      qrun_q      <= '0;
      nrun_q      <= '0;
      deadline_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (rec_valid_i) begin
            dcnt_q  <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DCNT_W'(DVD_W - 1)) begin
            step_q  <= STEP_MEAN_N;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_PK_N) begin
            state_q <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          if (out_free) begin
            label_q    <= label_nx;
            qrun_q     <= qrun_nx;
            nrun_q     <= nrun_nx;
            deadline_q <= deadline_nx;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // Hold the result until the sink takes it
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the datapath
  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      rec_q <= rec_i;
      dvd_q <= sum_mag[DVD_W-1:0];
      rem_q <= '0;
      neg_q <= sum_in[afl_pkg::SUM_W-1];
    end
    if (state_q == ST_DIV) begin
      dvd_q <= dvd_nx;
      rem_q <= rem_nx;
      if (dcnt_q == DCNT_W'(DVD_W - 1)) begin
        mean_q <= mean_nx;
      end
    end
    if (state_q == ST_MUL) begin
      unique case (step_q)
        STEP_MEAN_N: begin
          t_q    <= mul_p[afl_pkg::SUM_W-1:0];
          peak_q <= peak_nx;
        end
        STEP_CROSS:  v_q <= mul_p[WIDE_W-1:0];
        STEP_IR_SQ: begin
          prod_q <= mul_p[PROD_W-1:0];
          sq_q   <= sq_nx;
        end
        STEP_IR_N:   irn_q  <= mul_p[WIDE_W-1:0];
        STEP_LR_SQ:  prod_q <= mul_p[PROD_W-1:0];
        STEP_LR_N:   lrn_q  <= mul_p[WIDE_W-1:0];
        STEP_NR_SQ:  prod_q <= mul_p[PROD_W-1:0];
        STEP_NR_N:   nrn_q  <= mul_p[WIDE_W-1:0];
        STEP_PK_SQ:  prod_q <= mul_p[PROD_W-1:0];
        STEP_PK_N:   ppn_q  <= mul_p[WIDE_W-1:0];
        default: begin
        end
      endcase
    end
    if (load_out) begin
      out_q.label <= label_nx;
      out_q.peak  <= peak_q;
      out_q.mean  <= mean_q;
      out_q.sq    <= sq_q;
      out_q.cnt   <= rec_q.cnt;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_res_o   = out_q;

endmodule

FILE: sv/audio_frame_loudness_classifier.sv
// ----------------------------------------------------------------------------
// Audio frame loudness classifier
// Per-frame mean, centered square sum and peak deviation of 16-bit audio,
// with a Loud / Normal / Quiet label, Loud hold time and run counters.
//
//   Port group   Dir  Moves                           Handshake
//   s_axis_*     in   one sample per transfer         tvalid & tready
//   m_axis_*     out  one result per closed frame     tvalid & tready
//   cfg_*        in   one register write per transfer cfg_valid & cfg_ready
//
// Samples are taken one per cycle while the two-entry record queue has room.
// Each closed frame passes the classifier through a load, the bit-serial
// mean division, the steps on the shared multiplier and a classify step,
// while the front keeps taking samples of the next frame.
// Reset clears the accumulators, label state and registers to their defaults.
// A stalled result output holds the classifier; the front keeps running
// until the queue is full.
// ----------------------------------------------------------------------------
module audio_frame_loudness_classifier (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // [15:0] sample, [47:16] time_ms
  input  logic [afl_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  input  logic                                 s_axis_tlast_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [1:0] level_label, [17:2] peak_deviation, [33:18] frame_mean,
  // [73:34] centered_square_sum, [82:74] frame_samples, [87:83] zero
  output logic [afl_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [afl_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [afl_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  `include "audio_frame_loudness_classifier_assert.svh"

  afl_pkg::cfg_t                 cfg_q;
  afl_pkg::frame_rec_t           push_rec, pop_rec;
  afl_pkg::result_t              res;
  logic                          q_push, q_full, q_valid, q_pop;
  logic [afl_pkg::QCNT_W-1:0]    q_count;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= afl_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        afl_pkg::CFG_LOUD_RMS:       cfg_q.loud_rms       <= cfg_data_i[14:0];
        afl_pkg::CFG_LOUD_PEAK:      cfg_q.loud_peak      <= cfg_data_i;
        afl_pkg::CFG_TRANSIENT_PEAK: cfg_q.transient_peak <= cfg_data_i;
        afl_pkg::CFG_IMPULSE_PEAK:   cfg_q.impulse_peak   <= cfg_data_i;
        afl_pkg::CFG_IMPULSE_RMS:    cfg_q.impulse_rms    <= cfg_data_i[14:0];
        afl_pkg::CFG_NORMAL_RMS:     cfg_q.normal_rms     <= cfg_data_i[14:0];
        afl_pkg::CFG_NORMAL_PEAK:    cfg_q.normal_peak    <= cfg_data_i;
        afl_pkg::CFG_LOUD_HOLD:      cfg_q.hold_ms        <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Accumulate samples
  afl_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sample_i  (s_axis_tdata_i[15:0]),
    .last_i    (s_axis_tlast_i),
    .time_i    (s_axis_tdata_i[47:16]),
    .full_i    (q_full),
    .push_o    (q_push),
    .rec_o     (push_rec)
  );

  // Decouple accumulation from classification
  afl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (push_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rec_o   (pop_rec),
    .count_o (q_count)
  );

  // Finish and classify each frame
  afl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rec_valid_i (q_valid),
    .rec_i       (pop_rec),
    .rec_pop_o   (q_pop),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_res_o     (res)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata_o = {5'b00000, res.cnt, res.sq, res.mean, res.peak, res.label};

  // Checks
  `AFL_ASSERT_NEVER(a_label_code, clk_i, rst_ni, m_axis_tvalid_o && (res.label != afl_pkg::LABEL_QUIET) && (res.label != afl_pkg::LABEL_NORMAL) && (res.label != afl_pkg::LABEL_LOUD))
  `AFL_ASSERT_IMPL(a_frame_len, clk_i, rst_ni, m_axis_tvalid_o, (res.cnt != '0) && (res.cnt <= afl_pkg::CNT_W'(afl_pkg::FRAME_MAX)))
  `AFL_ASSERT_IMPL(a_flat_frame, clk_i, rst_ni, m_axis_tvalid_o && (res.sq == '0), res.peak == '0)
  `AFL_ASSERT_NEVER(a_push_full, clk_i, rst_ni, q_push && q_full)
  `AFL_ASSERT_IMPL(a_queue_fill, clk_i, rst_ni, q_valid, (q_count != '0) && (q_count <= afl_pkg::QCNT_W'(afl_pkg::QUEUE_DEPTH)))

endmodule
